// ===== rtl/krt_pkg.sv =====
package krt_pkg;

  localparam int Capacity = 64;
  localparam int IdxW = $clog2(Capacity);
  localparam int CntW = $clog2(Capacity + 1);
  localparam int OutCntW = 7;

  localparam logic [1:0] KIND_FREE = 2'd0;
  localparam logic [1:0] KIND_BIG = 2'd1;
  localparam logic [1:0] KIND_SMALL = 2'd2;
  localparam logic [1:0] KIND_HEAP = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_DUP = 2'd2;
  localparam logic [1:0] ST_MISS = 2'd3;

  localparam logic [1:0] ACT_INS = 2'd0;
  localparam logic [1:0] ACT_SRCH = 2'd1;
  localparam logic [1:0] ACT_DEL = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]  act;
    logic [1:0]  kind;
    logic [63:0] key;
    logic [63:0] addr;
    logic [63:0] size;
    logic [63:0] heap_ref;
  } cmd_t;

endpackage

// ===== rtl/keyed_region_table.sv =====
// keyed_region_table: region and heap tables sharing a 64-slot pool
// the back end takes a new item only when done with the last, after a one-slot-a-cycle key scan
// a two-entry queue takes items while the back end scans
// reset (rst_n low, synchronous): all slots free, free count full, queue empty
module keyed_region_table (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_opcode,
  input  logic [63:0] in_key,
  input  logic [63:0] in_addr_in,
  input  logic [63:0] in_size_in,
  input  logic [63:0] in_heap_ref_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [63:0] out_addr_out,
  output logic [63:0] out_size_out,
  output logic [63:0] out_heap_ref_out,
  output logic [6:0]  out_free_slots
);
  import krt_pkg::*;

  // decoded command queue between front and back
  logic q_valid, q_ready;
  cmd_t q_cmd;

  krt_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_opcode, .in_key, .in_addr_in,
    .in_size_in, .in_heap_ref_in, .q_valid, .q_ready, .q_cmd
  );

  // back end: scan, then read-modify-write of the matched or free slot
  krt_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .out_valid, .out_ready,
    .out_status, .out_addr_out, .out_size_out, .out_heap_ref_out, .out_free_slots
  );
endmodule

// ===== rtl/krt_front.sv =====
module krt_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [3:0]    in_opcode,
  input  logic [63:0]   in_key,
  input  logic [63:0]   in_addr_in,
  input  logic [63:0]   in_size_in,
  input  logic [63:0]   in_heap_ref_in,
  output logic          q_valid,
  input  logic          q_ready,
  output krt_pkg::cmd_t q_cmd
);
  import krt_pkg::*;

  // two-entry queue of decoded commands
  cmd_t       mem_r [2];
  logic       wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  cmd_t       dec;
  logic       push, pop;

  always_comb begin
    dec.key      = in_key;
    dec.addr     = in_addr_in;
    dec.size     = in_size_in;
    dec.heap_ref = in_heap_ref_in;
    dec.kind     = KIND_FREE;
    case (in_opcode)
      4'd0, 4'd3, 4'd6: dec.kind = KIND_BIG;
      4'd1, 4'd4, 4'd7: dec.kind = KIND_SMALL;
      4'd2, 4'd5, 4'd8: dec.kind = KIND_HEAP;
      default:          dec.kind = KIND_FREE;
    endcase
    case (in_opcode)
      4'd0, 4'd1, 4'd2: dec.act = ACT_INS;
      4'd3, 4'd4, 4'd5: dec.act = ACT_SRCH;
      4'd6, 4'd7, 4'd8: dec.act = ACT_DEL;
      default:          dec.act = ACT_NONE;
    endcase
    if (dec.kind != KIND_SMALL) dec.heap_ref = '0;
  end

  assign in_ready = (cnt_r != 2'd2);
  assign q_valid  = (cnt_r != 2'd0);
  assign q_cmd    = mem_r[rp_r];
  assign push     = in_valid && in_ready;
  assign pop      = q_valid && q_ready;

  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= dec;
  end
endmodule

// ===== rtl/krt_back.sv =====
module krt_back (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  output logic          q_ready,
  input  krt_pkg::cmd_t q_cmd,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [1:0]    out_status,
  output logic [63:0]   out_addr_out,
  output logic [63:0]   out_size_out,
  output logic [63:0]   out_heap_ref_out,
  output logic [6:0]    out_free_slots
);
  import krt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_DONE = 3'd3;
  localparam logic [2:0] S_RD   = 3'd4;
  localparam logic [2:0] S_RD2  = 3'd5;

  // kinds live in flops (reset to free); payload in memory
  logic [1:0]  kind_r [Capacity];
  logic [63:0] key_mem [Capacity];
  logic [63:0] addr_mem [Capacity];
  logic [63:0] size_mem [Capacity];
  logic [63:0] href_mem [Capacity];

  logic [2:0]      st_r, st_nxt;
  cmd_t            cmd_r;
  logic [IdxW:0]   ptr_r;
  logic [IdxW-1:0] rd_idx_r, hit_idx_r, free_idx_r;
  logic            hit_r, free_ok_r, rd_vld_r;
  logic [63:0]     rd_key_r;
  logic [1:0]      rd_kind_r;
  logic [CntW-1:0] free_cnt_r;
  logic [63:0]     ra_r, rs_r, rh_r;

  logic [1:0]  status_r;
  logic [63:0] oa_r, os_r, oh_r;
  logic        ov_r;

  logic same_tbl;
  always_comb begin
    if (rd_kind_r == KIND_FREE) same_tbl = 1'b0;
    else if (cmd_r.kind == KIND_HEAP) same_tbl = (rd_kind_r == KIND_HEAP);
    else same_tbl = (rd_kind_r != KIND_HEAP);
  end

  assign q_ready        = (st_r == S_IDLE);
  assign out_valid      = ov_r;
  assign out_status     = status_r;
  assign out_addr_out   = oa_r;
  assign out_size_out   = os_r;
  assign out_heap_ref_out = oh_r;
  assign out_free_slots = (free_cnt_r > CntW'(127)) ? 7'd127 : OutCntW'(free_cnt_r);

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      S_IDLE: if (q_valid) st_nxt = S_SCAN;
      S_SCAN: if (ptr_r == (IdxW+1)'(Capacity)) st_nxt = S_LAST;
      S_LAST: st_nxt = S_DONE;
      S_DONE: st_nxt = S_RD;
      S_RD:   st_nxt = S_RD2;
      S_RD2:  if (!ov_r || out_ready) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= S_IDLE;
      ov_r       <= 1'b0;
      free_cnt_r <= CntW'(Capacity);
      for (int i = 0; i < Capacity; i++) kind_r[i] <= KIND_FREE;
    end else begin
      st_r <= st_nxt;
      if (st_r == S_RD2 && (!ov_r || out_ready)) ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
      case (st_r)
        S_IDLE: begin
          cmd_r     <= q_cmd;
          ptr_r     <= '0;
          hit_r     <= 1'b0;
          free_ok_r <= 1'b0;
          rd_vld_r  <= 1'b0;
        end
        S_SCAN, S_LAST: begin
          // one slot read per cycle, its key compared in the cycle after the read
          if (ptr_r < (IdxW+1)'(Capacity)) begin
            rd_idx_r  <= ptr_r[IdxW-1:0];
            rd_key_r  <= key_mem[ptr_r[IdxW-1:0]];
            rd_kind_r <= kind_r[ptr_r[IdxW-1:0]];
            rd_vld_r  <= 1'b1;
            if (!free_ok_r && kind_r[ptr_r[IdxW-1:0]] == KIND_FREE) begin
              free_ok_r  <= 1'b1;
              free_idx_r <= ptr_r[IdxW-1:0];
            end
            ptr_r <= ptr_r + 1'b1;
          end else begin
            rd_vld_r <= 1'b0;
          end
          if (rd_vld_r && !hit_r && same_tbl && rd_key_r == cmd_r.key) begin
            hit_r     <= 1'b1;
            hit_idx_r <= rd_idx_r;
          end
        end
        S_DONE: begin
          ra_r <= addr_mem[hit_idx_r];
          rs_r <= size_mem[hit_idx_r];
          rh_r <= href_mem[hit_idx_r];
        end
        S_RD: ;
        S_RD2: begin
          if (!ov_r || out_ready) begin
            case (cmd_r.act)
              ACT_INS: begin
                oa_r <= '0; os_r <= '0; oh_r <= '0;
                if (!free_ok_r || free_cnt_r == '0) status_r <= ST_FULL;
                else if (hit_r) status_r <= ST_DUP;
                else begin
                  status_r <= ST_OK;
                  kind_r[free_idx_r] <= cmd_r.kind;
                  free_cnt_r <= free_cnt_r - 1'b1;
                end
              end
              ACT_SRCH: begin
                if (hit_r && kind_r[hit_idx_r] == cmd_r.kind) begin
                  status_r <= ST_OK;
                  oa_r <= ra_r; os_r <= rs_r; oh_r <= rh_r;
                end else begin
                  status_r <= ST_MISS;
                  oa_r <= '0; os_r <= '0; oh_r <= '0;
                end
              end
              ACT_DEL: begin
                oa_r <= '0; os_r <= '0; oh_r <= '0;
                if (hit_r && kind_r[hit_idx_r] == cmd_r.kind) begin
                  status_r <= ST_OK;
                  kind_r[hit_idx_r] <= KIND_FREE;
                  free_cnt_r <= free_cnt_r + 1'b1;
                end else begin
                  status_r <= ST_MISS;
                end
              end
              default: begin
                status_r <= ST_MISS;
                oa_r <= '0; os_r <= '0; oh_r <= '0;
              end
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  // payload memory written on a successful insert
  always_ff @(posedge clk) begin
    if (st_r == S_RD2 && (!ov_r || out_ready) && cmd_r.act == ACT_INS &&
        free_ok_r && free_cnt_r != '0 && !hit_r) begin
      key_mem[free_idx_r]  <= cmd_r.key;
      addr_mem[free_idx_r] <= cmd_r.addr;
      size_mem[free_idx_r] <= cmd_r.size;
      href_mem[free_idx_r] <= cmd_r.heap_ref;
    end
  end
endmodule

// ===== tb/sv/keyed_region_table_test.sv =====
module keyed_region_table_test;
  import krt_pkg::*;

  // action codes carried on in_opcode
  localparam logic [3:0] OP_INS_BIG   = 4'd0;
  localparam logic [3:0] OP_INS_SMALL = 4'd1;
  localparam logic [3:0] OP_INS_HEAP  = 4'd2;
  localparam logic [3:0] OP_SRCH_BIG  = 4'd3;
  localparam logic [3:0] OP_SRCH_SMALL = 4'd4;
  localparam logic [3:0] OP_SRCH_HEAP = 4'd5;
  localparam logic [3:0] OP_DEL_BIG   = 4'd6;
  localparam logic [3:0] OP_DEL_SMALL = 4'd7;
  localparam logic [3:0] OP_DEL_HEAP  = 4'd8;
  localparam logic [3:0] OP_LAST_USED = 4'd8;
  localparam logic [3:0] OP_MAX       = 4'd15;

  localparam int NumKeys = 48;
  localparam int RandomItems = 1190;
  localparam int SettleCycles = 2 * Capacity + 20;

  typedef struct {
    logic [1:0]  status;
    logic [63:0] addr;
    logic [63:0] size;
    logic [63:0] heap_ref;
    logic [6:0]  free_slots;
  } table_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [3:0] in_opcode = '0;
  logic [63:0] in_key = '0;
  logic [63:0] in_addr_in = '0;
  logic [63:0] in_size_in = '0;
  logic [63:0] in_heap_ref_in = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] out_status;
  logic [63:0] out_addr_out;
  logic [63:0] out_size_out;
  logic [63:0] out_heap_ref_out;
  logic [6:0] out_free_slots;

  // shadow copy of the slot pool
  logic [1:0]  pool_kind [Capacity];
  logic [63:0] pool_key  [Capacity];
  logic [63:0] pool_addr [Capacity];
  logic [63:0] pool_size [Capacity];
  logic [63:0] pool_href [Capacity];
  int free_left;

  table_result_t pending_results[$];
  logic [63:0] key_set [NumKeys];
  int error_count = 0;
  int results_seen = 0;
  int items_sent = 0;
  int full_hits = 0;
  int dup_hits = 0;
  int search_hits = 0;
  int burst_left = 0;

  keyed_region_table u_top (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // looks up a key within the table that holds entries of the given kind
  function automatic int find_entry(logic [63:0] k, logic [1:0] kind);
    for (int i = 0; i < Capacity; i++) begin
      if (pool_kind[i] != KIND_FREE && pool_key[i] == k &&
          ((kind == KIND_HEAP) == (pool_kind[i] == KIND_HEAP)))
        return i;
    end
    return -1;
  endfunction

  // applies one action to the shadow pool and returns what the block should give
  function automatic table_result_t apply_table_op(logic [3:0] op, logic [63:0] k,
                                                   logic [63:0] a, logic [63:0] s,
                                                   logic [63:0] h);
    table_result_t r;
    logic [1:0] kind;
    int slot;
    int idx;
    r = '{ST_MISS, '0, '0, '0, '0};
    kind = 2'(op % 3) + 2'd1;
    if (op <= OP_INS_HEAP) begin
      slot = -1;
      for (int i = Capacity - 1; i >= 0; i--)
        if (pool_kind[i] == KIND_FREE) slot = i;
      if (slot < 0 || free_left == 0) begin
        r.status = ST_FULL;
      end else if (find_entry(k, kind) >= 0) begin
        r.status = ST_DUP;
      end else begin
        pool_kind[slot] = kind;
        pool_key[slot] = k;
        pool_addr[slot] = a;
        pool_size[slot] = s;
        pool_href[slot] = (kind == KIND_SMALL) ? h : '0;
        free_left--;
        r.status = ST_OK;
      end
    end else if (op <= OP_LAST_USED) begin
      idx = find_entry(k, kind);
      if (idx >= 0 && pool_kind[idx] == kind) begin
        r.status = ST_OK;
        if (op <= OP_SRCH_HEAP) begin
          r.addr = pool_addr[idx];
          r.size = pool_size[idx];
          r.heap_ref = pool_href[idx];
        end else begin
          pool_kind[idx] = KIND_FREE;
          free_left++;
        end
      end
    end
    r.free_slots = (free_left > 127) ? 7'd127 : 7'(free_left);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch on %s at %0t: got %h, want %h", what, $time, got, want);
    error_count++;
  endtask

  // offers one item, keeps valid high across a burst, gaps between bursts
  task automatic send_item(logic [3:0] op, logic [63:0] k, logic [63:0] a,
                           logic [63:0] s, logic [63:0] h);
    int gap;
    table_result_t r;
    in_valid <= 1'b1;
    in_opcode <= op;
    in_key <= k;
    in_addr_in <= a;
    in_size_in <= s;
    in_heap_ref_in <= h;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    r = apply_table_op(op, k, a, s, h);
    if (r.status == ST_FULL) full_hits++;
    if (r.status == ST_DUP) dup_hits++;
    if (r.status == ST_OK && op >= OP_SRCH_BIG && op <= OP_SRCH_HEAP) search_hits++;
    pending_results.push_back(r);
    items_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 90);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(4, 40);
    end
  endtask

  // sender holds off until every outstanding result has come back
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // receiver stall pattern: one of four modes, picked anew at random at regular intervals
  int stall_mode = 0;
  int stall_cycle = 0;
  int stall_hold = 0;
  always @(posedge clk) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= ($urandom_range(0, 9) >= 3);
      2: out_ready <= (stall_cycle % 3 != 0);
      default: begin
        if (stall_hold > 0) begin
          stall_hold <= stall_hold - 1;
          out_ready <= 1'b0;
        end else begin
          out_ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) stall_hold <= $urandom_range(5, 40);
        end
      end
    endcase
  end

  // result checker: each accepted result against the oldest expectation
  always @(posedge clk) begin
    table_result_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("unexpected result at %0t with status %0d", $time, out_status);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status)
          report_mismatch("status", 64'(out_status), 64'(want.status));
        if (out_addr_out !== want.addr) report_mismatch("addr", out_addr_out, want.addr);
        if (out_size_out !== want.size) report_mismatch("size", out_size_out, want.size);
        if (out_heap_ref_out !== want.heap_ref)
          report_mismatch("heap ref", out_heap_ref_out, want.heap_ref);
        if (out_free_slots !== want.free_slots)
          report_mismatch("free slots", 64'(out_free_slots), 64'(want.free_slots));
      end
    end
  end

  // extremes of every field, each action, kind mismatch, duplicates, unused opcodes
  task automatic test_directed();
    logic [63:0] ones;
    ones = '1;
    send_item(OP_SRCH_BIG, '0, ones, ones, ones);
    send_item(OP_INS_BIG, '0, ones, '0, ones);
    send_item(OP_SRCH_BIG, '0, '0, '0, '0);
    send_item(OP_SRCH_SMALL, '0, '0, '0, '0);
    send_item(OP_DEL_SMALL, '0, '0, '0, '0);
    send_item(OP_INS_SMALL, ones, '0, ones, ones);
    send_item(OP_SRCH_SMALL, ones, '0, '0, '0);
    send_item(OP_SRCH_BIG, ones, '0, '0, '0);
    send_item(OP_INS_HEAP, '0, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA, ones);
    send_item(OP_INS_BIG, '0, '0, '0, '0);
    send_item(OP_INS_SMALL, '0, '0, '0, '0);
    send_item(OP_INS_HEAP, '0, '0, '0, '0);
    send_item(OP_SRCH_HEAP, '0, '0, '0, '0);
    send_item(OP_DEL_HEAP, '0, '0, '0, '0);
    send_item(OP_SRCH_HEAP, '0, '0, '0, '0);
    send_item(OP_DEL_BIG, '0, '0, '0, '0);
    send_item(OP_SRCH_BIG, '0, '0, '0, '0);
    send_item(OP_DEL_SMALL, ones, '0, '0, '0);
    for (logic [4:0] op = 5'(OP_LAST_USED) + 5'd1; op <= 5'(OP_MAX); op++)
      send_item(op[3:0], ones, ones, ones, ones);
    wait_drained();
  endtask

  // fill the pool, then a full pool must win over a duplicate key
  task automatic test_full_pool();
    for (int i = 0; i < Capacity; i++)
      send_item(i % 2 ? OP_INS_HEAP : OP_INS_BIG, 64'(i), rand64(), rand64(), rand64());
    send_item(OP_INS_HEAP, 64'd1, '0, '0, '0);
    send_item(OP_INS_SMALL, 64'd999, '0, '0, '0);
    send_item(OP_SRCH_HEAP, 64'd1, '0, '0, '0);
    send_item(OP_DEL_HEAP, 64'd1, '0, '0, '0);
    send_item(OP_INS_SMALL, 64'd1, '0, '0, rand64());
    send_item(OP_INS_HEAP, 64'd1, '0, '0, '0);
    send_item(OP_SRCH_SMALL, 64'd1, '0, '0, '0);
    for (int i = 0; i < Capacity; i++)
      send_item(i % 2 ? OP_DEL_HEAP : OP_DEL_BIG, 64'(i), '0, '0, '0);
    send_item(OP_DEL_SMALL, 64'd1, '0, '0, '0);
    wait_drained();
  endtask

  // random traffic over a small key set, alternating growth and shrink phases
  task automatic test_random_traffic();
    logic [3:0] op;
    logic [63:0] k;
    int roll;
    bit growing;
    growing = 1'b1;
    for (int i = 0; i < NumKeys; i++) key_set[i] = rand64();
    key_set[0] = '0;
    key_set[1] = '1;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 150 == 0) growing = !growing;
      roll = $urandom_range(0, 99);
      if (roll < 3) op = 4'($urandom_range(OP_LAST_USED + 1, OP_MAX));
      else if (roll < (growing ? 55 : 20)) op = 4'($urandom_range(OP_INS_BIG, OP_INS_HEAP));
      else if (roll < (growing ? 80 : 50)) op = 4'($urandom_range(OP_SRCH_BIG, OP_SRCH_HEAP));
      else op = 4'($urandom_range(OP_DEL_BIG, OP_DEL_HEAP));
      k = ($urandom_range(0, 19) == 0) ? rand64() : key_set[$urandom_range(0, NumKeys - 1)];
      send_item(op, k, rand64(), rand64(), rand64());
      if (n == RandomItems / 2) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    for (int i = 0; i < Capacity; i++) begin
      pool_kind[i] = KIND_FREE;
      pool_key[i] = '0;
      pool_addr[i] = '0;
      pool_size[i] = '0;
      pool_href[i] = '0;
    end
    free_left = Capacity;
    test_directed();
    test_full_pool();
    test_random_traffic();
    repeat (SettleCycles) @(posedge clk);
    $display("%0d items sent, %0d results checked", items_sent, results_seen);
    $display("covered: %0d full-pool inserts, %0d duplicate inserts, %0d search hits",
             full_hits, dup_hits, search_hits);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #2000000;
    $display("timeout with %0d results outstanding", pending_results.size());
    $display("simulation failed");
    $finish;
  end

endmodule
